FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DTD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dtd assertion failed");

// expression must never be true outside reset
`define DTD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("dtd forbidden condition seen");

`endif

FILE: hw/rtl/dtd_pkg.sv
// ----------------------------------------------------------------------------
// dtd_pkg
// types and constants of the disciplined tick divider
// ----------------------------------------------------------------------------
package dtd_pkg;

  localparam int unsigned RatioW = 5;
  localparam int unsigned PhaseW = 6;   // holds -1 .. 31
  localparam logic [RatioW-1:0] RatioReset = RatioW'(4);

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_POST_DIFF = 2'd1,
    OP_POST_ADJ  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               jam;
    logic signed [63:0] difference;
    logic signed [15:0] adjust_amount;
  } in_item_t;

  typedef struct packed {
    logic               divided_tick;
    logic        [63:0] system_count;
    logic signed [15:0] remaining_adjust;
    logic        [31:0] ticks_since_adjust;
  } out_item_t;

  // handshake between the input stage and the update stage
  typedef struct packed {
    logic adv;
  } stage_ctrl_t;

endpackage

FILE: hw/rtl/disciplined_tick_divider.sv
// ----------------------------------------------------------------------------
// disciplined_tick_divider
// divides second-flag ticks into a 64-bit steerable system tick count
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_ready_o   in_item_i   (in_item_t)
//   out      from block out_valid_o / out_ready_i out_item_o  (out_item_t)
//   cfg      to block   cfg_valid_i / cfg_ready_o cfg_data_i  (divide ratio)
//
// one item per cycle sustained while out_ready_i is high; an item's result passes
// through the input register, then the result register
// all counter updates for an item happen in one pass before the result reg
// reset clears the valid flags and divider state and sets the divide ratio to 4;
// the item and result data registers are not reset; no clearing pass; a stalled
// result holds the result register and then the input register, in_ready_o falls only when both are full
// ----------------------------------------------------------------------------
module disciplined_tick_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [dtd_pkg::RatioW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  dtd_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output dtd_pkg::out_item_t         out_item_o
);
  import dtd_pkg::*;

  stage_ctrl_t ctrl;
  logic        st_vld;
  in_item_t    st_item;

  assign cfg_ready_o = 1'b1;

  dtd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .adv_i      (ctrl.adv),
    .vld_o      (st_vld),
    .item_o     (st_item)
  );

  dtd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (st_item),
    .ctrl_o      (ctrl),
    .in_vld_i    (st_vld),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: hw/rtl/dtd_in_reg.sv
// ----------------------------------------------------------------------------
// dtd_in_reg
// input register stage, moves forward whenever the update stage advances
// ----------------------------------------------------------------------------
module dtd_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dtd_pkg::in_item_t in_item_i,
  input  logic              adv_i,
  output logic              vld_o,
  output dtd_pkg::in_item_t item_o
);
  import dtd_pkg::*;

  logic     vld_q, vld_d;
  in_item_t item_q;

  assign in_ready_o = !vld_q || adv_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

FILE: hw/rtl/dtd_core.sv
// ----------------------------------------------------------------------------
// dtd_core
// divider state, one update per item, and the result register
// ----------------------------------------------------------------------------
module dtd_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [dtd_pkg::RatioW-1:0] cfg_data_i,
  input  dtd_pkg::in_item_t          item_i,
  output dtd_pkg::stage_ctrl_t       ctrl_o,
  input  logic                       in_vld_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output dtd_pkg::out_item_t         out_item_o
);
  import dtd_pkg::*;

  logic [RatioW-1:0]        ratio_q;
  logic signed [PhaseW-1:0] phase_q, phase_d, phase_inc;
  logic signed [1:0]        offset_q, offset_d;
  logic [63:0]              tick_q, tick_d, jam_add;
  logic                     pjam_q, pjam_d;
  logic [63:0]              pdiff_q, pdiff_d;
  logic                     pflag_q, pflag_d;
  logic signed [15:0]       padj_q, padj_d, padj_kept;
  logic signed [15:0]       active_q, active_d, active_ld;
  logic [31:0]              intv_q, intv_d, intv_base;
  logic                     out_vld_q, out_vld_d;
  out_item_t                out_q, out_d;
  logic                     adv, fire, done;

  assign adv  = !out_vld_q || out_ready_i;
  assign fire = in_vld_i && adv;

  assign ctrl_o.adv = adv;

  assign phase_inc = phase_q + PhaseW'(1);
  assign done      = (item_i.op == OP_TICK) &&
                     (phase_inc >= $signed({1'b0, ratio_q}));

  // jam folds the queued difference into the same add as the tick
  assign jam_add   = pjam_q ? pdiff_q : 64'd0;
  assign padj_kept = pjam_q ? 16'sd0 : padj_q;
  assign intv_base = pjam_q ? 32'd0 : intv_q;
  assign active_ld = pflag_q ? padj_kept : active_q;

  always_comb begin
    phase_d  = phase_q;
    offset_d = offset_q;
    tick_d   = tick_q;
    pjam_d   = pjam_q;
    pdiff_d  = pdiff_q;
    pflag_d  = pflag_q;
    padj_d   = padj_q;
    active_d = active_q;
    intv_d   = intv_q;
    if (fire) begin
      case (item_i.op)
        OP_TICK: begin
          if (done) begin
            phase_d  = PhaseW'(offset_q);
            tick_d   = tick_q + jam_add + 64'd1;
            pjam_d   = 1'b0;
            pflag_d  = 1'b0;
            padj_d   = pflag_q ? 16'sd0 : padj_kept;
            intv_d   = intv_base + 32'd1;
            offset_d = 2'sd0;
            active_d = active_ld;
            // spend one adjustment tick through next cycle's phase
            if (active_ld < 0) begin
              offset_d = 2'sd1;
              active_d = active_ld + 16'sd1;
            end else if (active_ld > 0) begin
              offset_d = -2'sd1;
              active_d = active_ld - 16'sd1;
            end
          end else begin
            phase_d = phase_inc;
          end
        end
        OP_POST_DIFF: begin
          pjam_d  = item_i.jam;
          pdiff_d = item_i.difference;
        end
        OP_POST_ADJ: begin
          padj_d  = item_i.adjust_amount;
          pflag_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (adv) begin
      out_vld_d = in_vld_i;
    end
    if (fire) begin
      out_d.divided_tick       = done;
      out_d.system_count       = tick_d;
      out_d.remaining_adjust   = active_d;
      out_d.ticks_since_adjust = intv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q   <= RatioReset;
      phase_q   <= '0;
      offset_q  <= '0;
      tick_q    <= '0;
      pjam_q    <= 1'b0;
      pdiff_q   <= '0;
      pflag_q   <= 1'b0;
      padj_q    <= '0;
      active_q  <= '0;
      intv_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ratio_q <= cfg_data_i;
      end
      phase_q   <= phase_d;
      offset_q  <= offset_d;
      tick_q    <= tick_d;
      pjam_q    <= pjam_d;
      pdiff_q   <= pdiff_d;
      pflag_q   <= pflag_d;
      padj_q    <= padj_d;
      active_q  <= active_d;
      intv_q    <= intv_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

FILE: hw/rtl/dtd_checker.sv
// ----------------------------------------------------------------------------
// dtd_checker
// port-level checks on the disciplined tick divider, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [dtd_pkg::RatioW-1:0] cfg_data_i,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input dtd_pkg::in_item_t          in_item_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input dtd_pkg::out_item_t         out_item_o
);
  import dtd_pkg::*;

  // a stalled result stays put
  `DTD_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))

  // a ready sink never back-pressures the input
  `DTD_ASSERT(a_in_flows, clk_i, rst_ni, out_ready_i |-> in_ready_o)

  // the ratio register takes a write at any time
  `DTD_ASSERT_NEVER(a_cfg_blocked, clk_i, rst_ni, cfg_valid_i && !cfg_ready_o)

  // input can only block while a finished result waits
  `DTD_ASSERT(a_block_cause, clk_i, rst_ni,
    !in_ready_o |-> out_valid_o && !out_ready_i)

endmodule

bind disciplined_tick_divider dtd_checker u_dtd_checker (.*);

FILE: test/disciplined_tick_divider_test.sv
// ----------------------------------------------------------------------------
// disciplined_tick_divider_test
// self-checking regression of the disciplined tick divider
//
// a directed set of items covers the field extremes, every op, jams, queued
// adjustments and out-of-range ratios; random traffic then runs at a range
// of divide ratios under three idle patterns. a local model of the divider
// predicts every result item, which is checked field by field in order.
// ----------------------------------------------------------------------------
module disciplined_tick_divider_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dtd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned ReportLimit = 50;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [RatioW-1:0]   cfg_data_i = RatioReset;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;

  // model of the divider state
  logic [RatioW-1:0] ratio_q = RatioReset;
  int                phase_acc = 0;
  int                phase_trim = 0;
  logic [63:0]       count_q = '0;
  logic              jam_q = 1'b0;
  logic [63:0]       diff_q = '0;
  logic              adj_flag_q = 1'b0;
  int                adj_queued = 0;
  int                adj_live = 0;
  logic [31:0]       interval_q = '0;

  out_item_t predicted_counts[$];

  disciplined_tick_divider dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic out_item_t advance_divider(input in_item_t it);
    out_item_t res;
    logic      divided;
    divided = 1'b0;
    case (it.op)
      OP_TICK: begin
        phase_acc++;
        if (phase_acc >= int'(ratio_q)) begin
          divided = 1'b1;
          phase_acc = phase_trim;
          phase_trim = 0;
          count_q = count_q + 64'd1;
          if (jam_q) begin
            count_q = count_q + diff_q;
            adj_queued = 0;
            interval_q = '0;
            jam_q = 1'b0;
          end
          if (adj_flag_q) begin
            adj_flag_q = 1'b0;
            adj_live = adj_queued;
            adj_queued = 0;
          end
          // a negative adjustment shortens the next cycle, a positive one stretches it
          if (adj_live < 0) begin
            phase_trim = 1;
            adj_live++;
          end else if (adj_live > 0) begin
            phase_trim = -1;
            adj_live--;
          end
          interval_q = interval_q + 32'd1;
        end
      end
      OP_POST_DIFF: begin
        jam_q = it.jam;
        diff_q = it.difference;
      end
      OP_POST_ADJ: begin
        adj_queued = it.adjust_amount;
        adj_flag_q = 1'b1;
      end
      default: begin
      end
    endcase
    res.divided_tick = divided;
    res.system_count = count_q;
    res.remaining_adjust = adj_live[15:0];
    res.ticks_since_adjust = interval_q;
    return res;
  endfunction

  function automatic in_item_t item_of(input logic [1:0] op, input logic jam,
                                       input logic [63:0] diff, input logic [15:0] adj);
    in_item_t it;
    it.op = op_e'(op);
    it.jam = jam;
    it.difference = diff;
    it.adjust_amount = adj;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    it.op = OP_TICK;
    it.jam = 1'($urandom_range(0, 1));
    it.difference = {$urandom, $urandom};
    it.adjust_amount = 16'($urandom);
    if (pick >= 70 && pick < 80) begin
      it.op = OP_POST_DIFF;
      case ($urandom_range(0, 3))
        0: it.difference = 64'($urandom_range(0, 40)) - 64'd20;
        1: it.difference = {1'b1, 63'd0};
        2: it.difference = {1'b0, {63{1'b1}}};
        default: begin
        end
      endcase
    end else if (pick >= 80 && pick < 97) begin
      it.op = OP_POST_ADJ;
      case ($urandom_range(0, 9))
        0: it.adjust_amount = 16'h8000;
        1: it.adjust_amount = 16'h7fff;
        2: begin
        end
        default: it.adjust_amount = 16'($urandom_range(0, 12)) - 16'd6;
      endcase
    end else if (pick >= 97) begin
      it.op = op_e'(OP_UNUSED);
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < ReportLimit)
      $display("%0t mismatch %s: got %h, predicted %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // result side: check against the oldest prediction, then set ready for the next edge
  always @(posedge clk_i) begin : check_results
    out_item_t golden;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_counts.size() == 0) begin
        report_mismatch("result with nothing predicted", out_item_o.system_count, '0);
      end else begin
        golden = predicted_counts.pop_front();
        if (out_item_o.divided_tick !== golden.divided_tick)
          report_mismatch("divided_tick", 64'(out_item_o.divided_tick),
                          64'(golden.divided_tick));
        if (out_item_o.system_count !== golden.system_count)
          report_mismatch("system_count", out_item_o.system_count, golden.system_count);
        if (out_item_o.remaining_adjust !== golden.remaining_adjust)
          report_mismatch("remaining_adjust", 64'(out_item_o.remaining_adjust),
                          64'(golden.remaining_adjust));
        if (out_item_o.ticks_since_adjust !== golden.ticks_since_adjust)
          report_mismatch("ticks_since_adjust", 64'(out_item_o.ticks_since_adjust),
                          64'(golden.ticks_since_adjust));
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // valid is left high on return so back-to-back items need no second assignment
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_counts.push_back(advance_divider(it));
  endtask

  task automatic drain_results(input int settle_cycles);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_counts.size() != 0);
    repeat (settle_cycles) @(posedge clk_i);
  endtask

  task automatic write_ratio(input logic [RatioW-1:0] value);
    drain_results(SettleCycles);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ratio_q = value;
  endtask

  task automatic run_random_traffic(input logic [RatioW-1:0] ratio, input int item_total);
    write_ratio(ratio);
    for (int n = 0; n < item_total; n++) begin
      // at the midpoint and at random points the sender holds off until every result is back
      if (n == item_total / 2 || $urandom_range(0, 149) == 0)
        drain_results(0);
      send_item(random_item());
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // unused op straight after reset, junk in every field
    send_item(item_of(OP_UNUSED, 1'b1, '1, '1));
    send_item(item_of(OP_TICK, 1'b1, '1, '1));
    send_item(item_of(OP_TICK, 1'b0, '0, '0));
    send_item(item_of(OP_TICK, 1'b0, '0, '0));
    send_item(item_of(OP_TICK, 1'b0, '0, '0));
    // jam posted then cancelled by a second post with jam clear
    send_item(item_of(OP_POST_DIFF, 1'b1, {1'b0, {63{1'b1}}}, '0));
    send_item(item_of(OP_POST_DIFF, 1'b0, {1'b1, 63'd0}, '0));
    repeat (4) send_item(item_of(OP_TICK, 1'b0, '0, '0));
    // jam while an adjustment is queued: the adjustment loads as zero
    send_item(item_of(OP_POST_ADJ, 1'b0, '0, 16'h7fff));
    send_item(item_of(OP_POST_DIFF, 1'b1, '1, '0));
    repeat (4) send_item(item_of(OP_TICK, 1'b0, '0, '0));
    send_item(item_of(OP_POST_ADJ, 1'b1, '1, 16'h8000));
    repeat (4) send_item(item_of(OP_TICK, 1'b0, '0, '0));
    send_item(item_of(OP_POST_DIFF, 1'b1, {1'b1, 63'd0}, '0));
    repeat (3) send_item(item_of(OP_TICK, 1'b0, '0, '0));
    // ratio below the current phase, then zero: every tick completes a cycle
    write_ratio(5'd1);
    repeat (2) send_item(item_of(OP_TICK, 1'b0, '0, '0));
    write_ratio(5'd0);
    repeat (2) send_item(item_of(OP_TICK, 1'b0, '0, '0));
  endtask

  task automatic test_sender_light_receiver_heavy();
    send_idle_pct = 17;
    recv_idle_pct = 55;
    run_random_traffic(5'd2, 210);
    run_random_traffic(5'd16, 210);
    run_random_traffic(RatioReset, 210);
  endtask

  task automatic test_sender_heavy_receiver_light();
    send_idle_pct = 55;
    recv_idle_pct = 17;
    run_random_traffic(5'd0, 210);
    run_random_traffic(5'd31, 210);
    run_random_traffic(5'd9, 210);
  endtask

  task automatic test_no_idling();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(5'd1, 160);
    run_random_traffic(5'd17, 160);
    run_random_traffic(5'($urandom_range(2, 16)), 160);
    run_random_traffic(5'($urandom_range(0, 31)), 160);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_sender_light_receiver_heavy();
    test_sender_heavy_receiver_light();
    test_no_idling();
    drain_results(SettleCycles);
    if (mismatch_count == 0 && predicted_counts.size() == 0) begin
      $display("disciplined_tick_divider regression: pass");
    end else begin
      $display("disciplined_tick_divider regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("disciplined_tick_divider regression: fail");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/dtd_pkg.sv
hw/rtl/dtd_in_reg.sv
hw/rtl/dtd_core.sv
hw/rtl/disciplined_tick_divider.sv
hw/rtl/dtd_checker.sv
test/disciplined_tick_divider_test.sv
